// ----- hw/rtl/ffpe_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpe_pkg: shared types, constants and AES helpers
// Feistel value split, key size codes, s-box and byte-column arithmetic.
// ----------------------------------------------------------------------------
package ffpe_pkg;

   localparam int ValueBits = 48;
   localparam int HalfBits = ValueBits / 2;
   localparam int FeistelRounds = 8;
   localparam int RoundBits = $clog2(FeistelRounds);
   localparam int DigitBits = 8;
   localparam int HalfDigits = HalfBits / DigitBits;
   localparam int HalfCntBits = $clog2(HalfDigits + 1);
   localparam int KeySlots = 15;
   localparam int KeyIdxBits = 4;
   localparam int WordCntBits = 6;

   typedef enum logic [2:0] {
      CSR_KEY_WORD_0 = 3'd0,
      CSR_KEY_WORD_1 = 3'd1,
      CSR_KEY_WORD_2 = 3'd2,
      CSR_KEY_WORD_3 = 3'd3,
      CSR_KEY_SIZE   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KEY_128 = 2'd0,
      KEY_192 = 2'd1,
      KEY_256 = 2'd2,
      KEY_RSV = 2'd3
   } key_size_type;

   typedef enum logic [1:0] {
      KX_IDLE,
      KX_RUN
   } kx_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_AES,
      ST_MIX,
      ST_DONE
   } core_state_type;

   typedef struct packed {
      logic busy;
      logic [3:0] last_round;
   } kx_status_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tbl [256];
      tbl = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tbl[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // subword on a 32-bit word, byte 0 in bits 31:24
   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // one aes round on a block with byte 0 in bits 127:120
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
      for (int i = 0; i < 16; i++) t[i] = sbox(b[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]);
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
      return r;
   endfunction

endpackage

// ----- hw/rtl/ffpe_key_expand.sv -----
// ----------------------------------------------------------------------------
// ffpe_key_expand: aes key schedule
// Expands the key one 32-bit word per cycle into the round key memory.
// ----------------------------------------------------------------------------
module ffpe_key_expand (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [255:0] key,
   input  logic [1:0] key_size,
   input  logic [ffpe_pkg::KeyIdxBits-1:0] rd_idx,
   output logic [127:0] rd_key,
   output ffpe_pkg::kx_status_type status
);

   ffpe_pkg::kx_state_type state_ff, state_in;
   logic [ffpe_pkg::WordCntBits-1:0] cnt_ff, cnt_in;
   logic [2:0] sub_ff, sub_in;      // word index mod nk
   logic [7:0] rcon_ff, rcon_in;
   logic [31:0] win_ff [8];         // sliding window of last nk words
   logic [31:0] win_in [8];
   logic [127:0] mem [ffpe_pkg::KeySlots];
   logic [95:0] row_ff, row_in;
   logic [3:0] nk, nr;
   logic [ffpe_pkg::WordCntBits-1:0] total;
   logic [31:0] t, neww;
   logic wr_en;

   always_comb begin
      unique case (ffpe_pkg::key_size_type'(key_size))
         ffpe_pkg::KEY_128: begin nk = 4'd4; nr = 4'd10; end
         ffpe_pkg::KEY_192: begin nk = 4'd6; nr = 4'd12; end
         default:           begin nk = 4'd8; nr = 4'd14; end
      endcase
      total = ffpe_pkg::WordCntBits'(4 * (nr + 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffpe_pkg::KX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      sub_ff <= sub_in;
      rcon_ff <= rcon_in;
      win_ff <= win_in;
      row_ff <= row_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sub_in = sub_ff;
      rcon_in = rcon_ff;
      win_in = win_ff;
      row_in = row_ff;
      wr_en = 1'b0;
      // window: win[nk-1] is newest, win[0] is w[i-nk]
      t = win_ff[nk[2:0] - 3'd1];
      if (sub_ff == 3'd0) begin
         t = ffpe_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && sub_ff == 3'd4) begin
         t = ffpe_pkg::sub_word(t);
      end
      neww = (cnt_ff < {2'b0, nk}) ? key[255 - 32*cnt_ff[2:0] -: 32] : (win_ff[0] ^ t);
      unique case (state_ff)
         ffpe_pkg::KX_IDLE: begin
            if (start) begin
               state_in = ffpe_pkg::KX_RUN;
               cnt_in = '0;
               sub_in = '0;
               rcon_in = 8'h01;
            end
         end
         ffpe_pkg::KX_RUN: begin
            for (int j = 0; j < 7; j++) win_in[j] = win_ff[j + 1];
            for (int j = 0; j < 8; j++) begin
               if (j == nk - 4'd1) win_in[j] = neww;
            end
            if (cnt_ff >= {2'b0, nk}) begin
               if (sub_ff == 3'd0) rcon_in = ffpe_pkg::xtime(rcon_ff);
            end
            sub_in = (sub_ff == nk[2:0] - 3'd1) ? 3'd0 : sub_ff + 3'd1;
            if (cnt_ff < {2'b0, nk}) sub_in = (cnt_ff[2:0] == nk[2:0] - 3'd1) ? 3'd0 : cnt_ff[2:0] + 3'd1;
            row_in = {row_ff[63:0], neww};
            wr_en = cnt_ff[1:0] == 2'd3;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == total - 1'b1) state_in = ffpe_pkg::KX_IDLE;
            if (start) begin
               cnt_in = '0;
               sub_in = '0;
               rcon_in = 8'h01;
               state_in = ffpe_pkg::KX_RUN;
            end
         end
         default: state_in = ffpe_pkg::KX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[cnt_ff[5:2]] <= {row_ff, neww};
      rd_key <= mem[rd_idx];
   end

   assign status.busy = state_ff == ffpe_pkg::KX_RUN || start;
   assign status.last_round = nr;

endmodule

// ----- hw/rtl/feistel_fpe_aes_48bit.sv -----
// ----------------------------------------------------------------------------
// feistel_fpe_aes_48bit: 48-bit feistel format-preserving cipher on aes
// Eight feistel rounds over 24-bit halves, aes round function, serial add.
// ----------------------------------------------------------------------------
//  channel | ports         | beat
//  req     | req_valid/rdy | cmd, value_in, tweak_in
//  rsp     | rsp_valid/rdy | value_out
//  csr     | csr_we        | csr_index, csr_wdata
// one item at a time; per feistel round: a load with the first key add, nr aes
// rounds (one round per cycle, key memory read one ahead), a step to pick the
// low bytes and an 8-bit serial add/sub over the three bytes of the half;
// the accept and the output step frame the eight rounds of an item.
// after reset and after each csr write to a key word or the key size the key
// schedule runs, one word a cycle, during which no request is taken.
// a waiting response does not block the next request being accepted.
module feistel_fpe_aes_48bit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_cmd,
   input  logic [47:0] req_value_in,
   input  logic [63:0] req_tweak_in,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [47:0] rsp_value_out,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int H = ffpe_pkg::HalfBits;

   logic [63:0] kw_ff [4];
   logic [1:0] ksz_ff;
   logic kx_start_ff;
   ffpe_pkg::kx_status_type kx_st;
   logic [127:0] rkey;

   ffpe_pkg::core_state_type state_ff, state_in;
   logic dec_ff, dec_in;
   logic [63:0] tw_ff, tw_in;
   logic [H-1:0] l_ff, l_in, r_ff, r_in;
   logic [ffpe_pkg::RoundBits-1:0] k_ff, k_in;
   logic [3:0] ar_ff, ar_in;
   logic [127:0] s_ff, s_in;
   logic [H-1:0] y_ff, y_in;
   logic [H-1:0] sum_ff, sum_in;
   logic [ffpe_pkg::HalfCntBits-1:0] dg_ff, dg_in;
   logic cy_ff, cy_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [47:0] out_ff, out_in;
   logic [3:0] rd_idx;
   logic [ffpe_pkg::RoundBits-1:0] fi;
   logic [31:0] w;
   logic [127:0] blk;
   logic [8:0] dsum;
   logic [7:0] ydig;

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff <= '{default: '0};
         ksz_ff <= ffpe_pkg::KEY_256;
         kx_start_ff <= 1'b1;
      end else begin
         kx_start_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               ffpe_pkg::CSR_KEY_WORD_0: kw_ff[0] <= csr_wdata;
               ffpe_pkg::CSR_KEY_WORD_1: kw_ff[1] <= csr_wdata;
               ffpe_pkg::CSR_KEY_WORD_2: kw_ff[2] <= csr_wdata;
               ffpe_pkg::CSR_KEY_WORD_3: kw_ff[3] <= csr_wdata;
               ffpe_pkg::CSR_KEY_SIZE:   ksz_ff <= csr_wdata[1:0];
               default: ;
            endcase
            if (csr_index <= ffpe_pkg::CSR_KEY_SIZE) kx_start_ff <= 1'b1;
         end
      end
   end

   ffpe_key_expand u_kx (
      .clock(clock),
      .reset(reset),
      .start(kx_start_ff),
      .key({kw_ff[0], kw_ff[1], kw_ff[2], kw_ff[3]}),
      .key_size(ksz_ff),
      .rd_idx(rd_idx),
      .rd_key(rkey),
      .status(kx_st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffpe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dec_ff <= dec_in;
      tw_ff <= tw_in;
      l_ff <= l_in;
      r_ff <= r_in;
      k_ff <= k_in;
      ar_ff <= ar_in;
      s_ff <= s_in;
      y_ff <= y_in;
      sum_ff <= sum_in;
      dg_ff <= dg_in;
      cy_ff <= cy_in;
      out_ff <= out_in;
   end

   assign fi = dec_ff ? ffpe_pkg::RoundBits'(ffpe_pkg::FeistelRounds - 1) - k_ff : k_ff;
   assign w = (fi[0] ? tw_ff[63:32] : tw_ff[31:0]) ^ 32'(fi);
   assign blk = {r_ff[7:0], r_ff[15:8], r_ff[23:16], 8'h00, 64'h0,
                 w[7:0], w[15:8], w[23:16], w[31:24]};
   assign ydig = y_ff[7:0];
   assign dsum = dec_ff ? ({1'b0, l_ff[7:0]} - {1'b0, ydig} - {8'h0, cy_ff})
                        : ({1'b0, l_ff[7:0]} + {1'b0, ydig} + {8'h0, cy_ff});

   always_comb begin
      state_in = state_ff;
      dec_in = dec_ff;
      tw_in = tw_ff;
      l_in = l_ff;
      r_in = r_ff;
      k_in = k_ff;
      ar_in = ar_ff;
      s_in = s_ff;
      y_in = y_ff;
      sum_in = sum_ff;
      dg_in = dg_ff;
      cy_in = cy_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      rd_idx = ar_ff;
      unique case (state_ff)
         ffpe_pkg::ST_IDLE: begin
            req_ready = !kx_st.busy && !kx_start_ff;
            rd_idx = '0;
            if (req_valid && req_ready) begin
               dec_in = req_cmd;
               tw_in = req_tweak_in;
               l_in = req_value_in[47:H];
               r_in = req_value_in[H-1:0];
               k_in = '0;
               state_in = ffpe_pkg::ST_LOAD;
            end
         end
         ffpe_pkg::ST_LOAD: begin
            // rkey holds round key 0 here
            rd_idx = 4'd1;
            s_in = blk ^ rkey;
            ar_in = 4'd1;
            state_in = ffpe_pkg::ST_AES;
         end
         ffpe_pkg::ST_AES: begin
            rd_idx = (ar_ff == kx_st.last_round) ? 4'd0 : ar_ff + 4'd1;
            s_in = ffpe_pkg::aes_round(s_ff, ar_ff == kx_st.last_round) ^ rkey;
            ar_in = ar_ff + 4'd1;
            if (ar_ff == kx_st.last_round) begin
               state_in = ffpe_pkg::ST_MIX;
               dg_in = '0;
               cy_in = 1'b0;
            end
         end
         ffpe_pkg::ST_MIX: begin
            // little-endian low bytes of ciphertext, added (subtracted on decrypt) one byte per cycle
            rd_idx = '0;
            if (dg_ff == '0) begin
               y_in = {s_ff[111:104], s_ff[119:112], s_ff[127:120]};
               state_in = ffpe_pkg::ST_MIX;
               dg_in = dg_ff + 1'b1;
            end else begin
               sum_in = {dsum[7:0], sum_ff[H-1:8]};
               cy_in = dsum[8];
               l_in = {8'h0, l_ff[H-1:8]};
               y_in = {8'h0, y_ff[H-1:8]};
               dg_in = dg_ff + 1'b1;
               if (dg_ff == ffpe_pkg::HalfCntBits'(ffpe_pkg::HalfDigits)) begin
                  l_in = r_ff;
                  r_in = {dsum[7:0], sum_ff[H-1:8]};
                  k_in = k_ff + 1'b1;
                  if (k_ff == ffpe_pkg::RoundBits'(ffpe_pkg::FeistelRounds - 1)) begin
                     state_in = ffpe_pkg::ST_DONE;
                  end else begin
                     state_in = ffpe_pkg::ST_LOAD;
                  end
               end
            end
         end
         ffpe_pkg::ST_DONE: begin
            rd_idx = '0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_in = {r_ff, l_ff};
               state_in = ffpe_pkg::ST_IDLE;
            end
         end
         default: state_in = ffpe_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value_out = out_ff;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 48-bit feistel aes cipher
// Random bursty requests and stalled responses are checked against an
// in-bench feistel/aes predictor over several key settings.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        cmd;
      logic [47:0] value;
      logic [63:0] tweak;
   } cipher_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [47:0] req_value_in = '0;
   logic [63:0] req_tweak_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_value_out;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   feistel_fpe_aes_48bit DUT (.*);

   always #5 clock = ~clock;

   // predictor copy of the key registers
   logic [63:0] key_words [4];
   logic [1:0]  key_len;
   logic [7:0]  rkeys [15][16];
   int          aes_nr;

   cipher_beat_type pending_beats [$];
   logic [47:0]  expected_values [$];
   int  errors = 0;
   int  results_seen = 0;
   longint cycle_count = 0;
   bit  gen_done = 0;
   bit  hold_rsp = 0;
   int  hold_count = 0;
   int  burst_left = 0;
   int  gap_left = 0;

   localparam byte unsigned SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] gf_double(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic void build_round_keys();
      logic [7:0] kb [32];
      logic [7:0] w [60][4];
      logic [7:0] t [4];
      logic [7:0] rc, r0;
      int nk, total;
      rc = 8'h01;
      for (int i = 0; i < 32; i++) kb[i] = key_words[i / 8][63 - 8 * (i % 8) -: 8];
      nk = (key_len == ffpe_pkg::KEY_128) ? 4 : (key_len == ffpe_pkg::KEY_192) ? 6 : 8;
      aes_nr = nk + 6;
      total = 4 * (aes_nr + 1);
      for (int i = 0; i < nk; i++)
         for (int j = 0; j < 4; j++) w[i][j] = kb[4 * i + j];
      for (int i = nk; i < total; i++) begin
         for (int j = 0; j < 4; j++) t[j] = w[i - 1][j];
         if (i % nk == 0) begin
            r0 = t[0];
            t[0] = SBOX[t[1]] ^ rc;
            t[1] = SBOX[t[2]];
            t[2] = SBOX[t[3]];
            t[3] = SBOX[r0];
            rc = gf_double(rc);
         end else if (nk > 6 && i % nk == 4) begin
            for (int j = 0; j < 4; j++) t[j] = SBOX[t[j]];
         end
         for (int j = 0; j < 4; j++) w[i][j] = w[i - nk][j] ^ t[j];
      end
      for (int r = 0; r < 15; r++)
         for (int j = 0; j < 16; j++) rkeys[r][j] = 8'h00;
      for (int i = 0; i < total; i++)
         for (int j = 0; j < 4; j++) rkeys[i / 4][4 * (i % 4) + j] = w[i][j];
   endfunction

   // aes of the round block, returns low 24 bits of the little-endian output
   function automatic logic [23:0] round_prf(logic [31:0] rhalf, logic [31:0] tw);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      for (int i = 0; i < 16; i++) s[i] = 8'h00;
      for (int i = 0; i < 4; i++) begin
         s[i] = rhalf[8 * i +: 8];
         s[12 + i] = tw[8 * i +: 8];
      end
      for (int i = 0; i < 16; i++) s[i] ^= rkeys[0][i];
      for (int r = 1; r <= aes_nr; r++) begin
         for (int i = 0; i < 16; i++) t[i] = SBOX[s[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]];
         if (r != aes_nr) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               x = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ x ^ gf_double(a0 ^ a1);
               t[4*c+1] = a1 ^ x ^ gf_double(a1 ^ a2);
               t[4*c+2] = a2 ^ x ^ gf_double(a2 ^ a3);
               t[4*c+3] = a3 ^ x ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkeys[r][i];
      end
      return {s[2], s[1], s[0]};
   endfunction

   function automatic logic [47:0] feistel_cipher(cipher_beat_type b);
      logic [23:0] lh, rh, nr, y;
      int i;
      lh = b.value[47:24];
      rh = b.value[23:0];
      for (int k = 0; k < 8; k++) begin
         i = b.cmd ? 7 - k : k;
         y = round_prf({8'h00, rh},
                       ((i % 2) ? b.tweak[63:32] : b.tweak[31:0]) ^ 32'(i));
         nr = b.cmd ? lh - y : lh + y;
         lh = rh;
         rh = nr;
      end
      return {rh, lh};
   endfunction

   function automatic void set_key_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
         ffpe_pkg::CSR_KEY_WORD_0: key_words[0] = val;
         ffpe_pkg::CSR_KEY_WORD_1: key_words[1] = val;
         ffpe_pkg::CSR_KEY_WORD_2: key_words[2] = val;
         ffpe_pkg::CSR_KEY_WORD_3: key_words[3] = val;
         ffpe_pkg::CSR_KEY_SIZE:   key_len = val[1:0];
         default: return;
      endcase
      build_round_keys();
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void queue_beat(logic c, logic [47:0] v, logic [63:0] t);
      cipher_beat_type b;
      b.cmd = c;
      b.value = v;
      b.tweak = t;
      pending_beats.push_back(b);
   endfunction

   task automatic write_key_reg(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      set_key_reg(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_phase();
      wait (pending_beats.size() == 0 && !req_valid && expected_values.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && req_ready) begin
         expected_values.push_back(feistel_cipher(pending_beats[0]));
         void'(pending_beats.pop_front());
      end
      if (!reset && (!req_valid || req_ready)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            cipher_beat_type nb;
            nb = pending_beats[0];
            req_valid <= 1'b1;
            req_cmd <= nb.cmd;
            req_value_in <= nb.value;
            req_tweak_in <= nb.tweak;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 6);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_ready <= 1'b0;
      end else if (hold_rsp) begin
         hold_count <= 2000;
         hold_rsp <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (cycle_count[9:7] == 3'd5) ? ($urandom_range(0, 7) == 0)
                                                 : ($urandom_range(0, 3) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (expected_values.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $realtime, rsp_value_out);
            errors <= errors + 1;
         end else begin
            if (rsp_value_out !== expected_values[0]) begin
               $display("%0t: value_out mismatch, expected %h actual %h",
                        $realtime, expected_values[0], rsp_value_out);
               errors <= errors + 1;
            end
            void'(expected_values.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 3000000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      logic [63:0] kv [4];
      key_words[0] = '0; key_words[1] = '0; key_words[2] = '0; key_words[3] = '0;
      key_len = ffpe_pkg::KEY_256;
      build_round_keys();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed beats on the reset key
      queue_beat(1'b0, 48'h0, 64'h0);
      queue_beat(1'b1, 48'h0, 64'h0);
      queue_beat(1'b0, 48'hffff_ffff_ffff, '1);
      queue_beat(1'b1, 48'hffff_ffff_ffff, '1);
      queue_beat(1'b0, 48'hffffff_000000, 64'hffffffff_00000000);
      queue_beat(1'b1, 48'h000000_ffffff, 64'h00000000_ffffffff);
      queue_beat(1'b0, 48'h800000_000001, 64'h80000000_00000001);
      queue_beat(1'b1, 48'h123456_789abc, 64'h0123456789abcdef);
      drain_phase();
      // index beyond the list and key size three
      write_key_reg(3'd5, '1);
      write_key_reg(3'd7, 64'h55);
      write_key_reg(ffpe_pkg::CSR_KEY_WORD_0, '1);
      write_key_reg(ffpe_pkg::CSR_KEY_WORD_3, 64'h0f0e0d0c0b0a0908);
      write_key_reg(ffpe_pkg::CSR_KEY_SIZE, 64'(ffpe_pkg::KEY_RSV));
      queue_beat(1'b0, 48'h5a5a5a_a5a5a5, 64'hdeadbeef_cafef00d);
      queue_beat(1'b1, 48'h5a5a5a_a5a5a5, 64'hdeadbeef_cafef00d);
      queue_beat(1'b0, 48'hffff_ffff_ffff, 64'h0);
      drain_phase();

      for (int ph = 0; ph < 7; ph++) begin
         for (int k = 0; k < 4; k++) begin
            case (ph)
               0: kv[k] = '0;
               1: kv[k] = '1;
               default: kv[k] = rand64();
            endcase
            write_key_reg(3'(k), kv[k]);
         end
         write_key_reg(ffpe_pkg::CSR_KEY_SIZE,
                       (ph == 6) ? 64'(ffpe_pkg::KEY_RSV) : 64'(ph % 3));
         if (ph == 3) hold_rsp = 1;
         for (int n = 0; n < 250; n++) begin
            case ($urandom_range(0, 9))
               0: queue_beat(1'($urandom_range(0, 1)), '1, rand64());
               1: queue_beat(1'($urandom_range(0, 1)), '0, rand64());
               2: queue_beat(1'($urandom_range(0, 1)), 48'(rand64()), '0);
               default: queue_beat(1'($urandom_range(0, 1)), 48'(rand64()), rand64());
            endcase
         end
         drain_phase();
      end

      gen_done = 1;
      repeat (200) @(posedge clock);
      $display("run covered %0d result beats over 128/192/256-bit and reserved key sizes",
               results_seen);
      $display("with bursty requests, stalled responses and one long response hold-off");
      if (errors == 0 && expected_values.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
